>>> src/imu_sample_filter_calibrate_assert.svh
// Assertion macros used by the checker file of the sensor conditioning block.
`ifndef IMU_SAMPLE_FILTER_CALIBRATE_ASSERT_SVH
`define IMU_SAMPLE_FILTER_CALIBRATE_ASSERT_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define IMUSF_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("imusf: next-cycle check failed");

// Check that cons holds in the cycle after ante, reset included.
`define IMUSF_ASSERT_ALWAYS_NEXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("imusf: reset check failed");

`endif

>>> src/imusf_pkg.sv
// Shared types and helpers for the sensor conditioning block.
package imusf_pkg;

  // Q format value held in 32 bits
  typedef logic signed [31:0] q_t;

  // Shared multiply-accumulate widths
  localparam int MAC_AW = 34;
  localparam int MAC_BW = 30;
  localparam int ACC_W  = 64;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
    logic shl;
  } mac_ctl_t;

  // Filter history of one axis: inputs and outputs one and two samples back
  typedef struct packed {
    q_t x1;
    q_t x2;
    q_t y1;
    q_t y2;
  } hist_t;

  // Saturate a wide signed value to 32 bits
  function automatic q_t sat32(input logic signed [ACC_W-1:0] val);
    q_t res;
    if (val > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (val < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

endpackage

>>> src/imu_sample_filter_calibrate.sv
// Top level: IMU sample scaling, IIR low-pass and calibration over one shared MAC.
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tdata: x, y, z raw; tuser: sensor kind
// m_*       out  m_tvalid / m_tready  tdata: x, y, z out; tuser: sensor kind
// cfg_*     in   cfg_valid / cfg_ready index, 48-bit write data
//
// One sample at a time; all products go through one multiply-accumulate unit.
// An unused sensor kind returns zeros.
// Synchronous reset clears filter history, loads register defaults and idles the sequencer;
// a stalled result holds in the output register while the next sample is taken in.
module imu_sample_filter_calibrate #(
  parameter int FRAC_BITS = 16,
  parameter int AXES      = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // x_raw, y_raw, z_raw
  input  logic [1:0]  s_tuser,   // sensor_kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // x_out, y_out, z_out
  output logic [1:0]  m_tuser,   // sensor_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import imusf_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_FMAC  = 4'd2;
  localparam logic [3:0] ST_FEND  = 4'd3;
  localparam logic [3:0] ST_CSUB  = 4'd4;
  localparam logic [3:0] ST_CMAC  = 4'd5;
  localparam logic [3:0] ST_CEND  = 4'd6;
  localparam logic [3:0] ST_GEND  = 4'd7;
  localparam logic [3:0] ST_GSUB  = 4'd8;
  localparam logic [3:0] ST_AXEND = 4'd9;
  localparam logic [3:0] ST_MROW  = 4'd10;
  localparam logic [3:0] ST_MEND  = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  // Sensor kinds
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_MAG   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_ACC_OFF   = 3'd1;
  localparam logic [2:0] REG_ACC_GAIN  = 3'd2;
  localparam logic [2:0] REG_GYR_OFF   = 3'd3;
  localparam logic [2:0] REG_MAG_OFF   = 3'd4;
  localparam logic [2:0] REG_ROW0      = 3'd5;
  localparam logic [2:0] REG_ROW1      = 3'd6;
  localparam logic [2:0] REG_ROW2      = 3'd7;

  // Filter coefficients, Q28
  localparam logic signed [MAC_BW-1:0] COEF_B0  = 30'sd1487862;
  localparam logic signed [MAC_BW-1:0] COEF_B1  = 30'sd2975724;
  localparam logic signed [MAC_BW-1:0] COEF_B2  = 30'sd1487862;
  localparam logic signed [MAC_BW-1:0] COEF_NA1 = 30'sd477447832;
  localparam logic signed [MAC_BW-1:0] COEF_NA2 = -30'sd214963824;
  localparam logic signed [MAC_BW-1:0] GYRO_GAIN = 30'sd5214701;

  // Shifts and rounding constants
  localparam int ACC_SH  = FRAC_BITS - 8;
  localparam int GY_SH   = 32 - FRAC_BITS;
  localparam int OFF_LSH = (FRAC_BITS >= 12) ? FRAC_BITS - 12 : 0;
  localparam int OFF_RSH = (FRAC_BITS < 12) ? 12 - FRAC_BITS : 0;
  localparam logic signed [MAC_AW-1:0] OFF_RND =
    (OFF_RSH > 0) ? (34'sd1 <<< (OFF_RSH - 1)) : 34'sd0;
  localparam logic signed [ACC_W-1:0] GY_RND   = 64'sd1 <<< (GY_SH - 1);
  localparam logic signed [ACC_W-1:0] FILT_RND = 64'sd1 <<< 27;
  localparam logic signed [ACC_W-1:0] CAL_RND  = 64'sd1 <<< 13;
  localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

  // Configuration registers
  logic [2:0]  mode;
  logic [47:0] acc_off;
  logic [47:0] acc_gain;
  logic [47:0] gyr_off;
  logic [47:0] mag_off;
  logic [47:0] mat_row [0:2];

  // Sequencer and datapath registers
  logic [3:0]  state;
  logic [1:0]  axis;
  logic [2:0]  step;
  logic [1:0]  kind;
  logic [47:0] raw_vec;
  q_t          v;
  logic signed [MAC_AW-1:0] d;
  q_t          vals [0:2];
  q_t          calr [0:2];

  // Shared-unit and history signals
  mac_ctl_t                 ctl;
  logic signed [MAC_AW-1:0] op_a;
  logic signed [MAC_BW-1:0] op_b;
  logic signed [ACC_W-1:0]  acc;
  hist_t                    h_rd;
  hist_t                    h_wr;
  logic                     h_we;

  // Per-axis operands
  logic signed [15:0]       raw_cur;
  logic signed [15:0]       acc_off_ent;
  logic signed [15:0]       gain_ent;
  logic signed [15:0]       gyr_off_ent;
  logic signed [MAC_AW-1:0] acc_off_al;
  logic signed [MAC_AW-1:0] gyr_off_al;
  logic [1:0]               jj;
  logic [47:0]              sel_row;
  logic signed [15:0]       m_ent;
  logic signed [15:0]       bias_ent;
  q_t                       y_filt;
  logic                     mag_cal;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= '0;
      acc_off    <= '0;
      acc_gain   <= 48'h400040004000;
      gyr_off    <= '0;
      mag_off    <= '0;
      mat_row[0] <= 48'h000000004000;
      mat_row[1] <= 48'h000040000000;
      mat_row[2] <= 48'h400000000000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:     mode       <= cfg_data[2:0];
        REG_ACC_OFF:  acc_off    <= cfg_data;
        REG_ACC_GAIN: acc_gain   <= cfg_data;
        REG_GYR_OFF:  gyr_off    <= cfg_data;
        REG_MAG_OFF:  mag_off    <= cfg_data;
        REG_ROW0:     mat_row[0] <= cfg_data;
        REG_ROW1:     mat_row[1] <= cfg_data;
        REG_ROW2:     mat_row[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select per-axis entries
  assign raw_cur     = raw_vec[16*axis +: 16];
  assign acc_off_ent = acc_off[16*axis +: 16];
  assign gain_ent    = acc_gain[16*axis +: 16];
  assign gyr_off_ent = gyr_off[16*axis +: 16];
  assign acc_off_al  = ((MAC_AW'(acc_off_ent) <<< OFF_LSH) + OFF_RND) >>> OFF_RSH;
  assign gyr_off_al  = ((MAC_AW'(gyr_off_ent) <<< OFF_LSH) + OFF_RND) >>> OFF_RSH;
  assign jj          = (step < 3'd3) ? step[1:0] : 2'(step - 3'd3);
  assign sel_row     = mat_row[axis];
  assign m_ent       = sel_row[16*jj +: 16];
  assign bias_ent    = mag_off[16*jj +: 16];
  assign y_filt      = sat32((acc + FILT_RND) >>> 28);
  assign mag_cal     = (kind == KIND_MAG) && mode[2];

  // Drive the shared unit from the current step
  always_comb begin
    ctl  = '0;
    op_a = '0;
    op_b = '0;
    case (state)
      ST_LOAD: begin
        if (kind == KIND_GYRO) begin
          ctl.en  = 1'b1;
          ctl.clr = 1'b1;
          op_a    = MAC_AW'(raw_cur);
          op_b    = GYRO_GAIN;
        end
      end
      ST_FMAC: begin
        ctl.en  = 1'b1;
        ctl.clr = (step == 3'd0);
        case (step)
          3'd0: begin
            op_a = MAC_AW'(v);
            op_b = COEF_B0;
          end
          3'd1: begin
            op_a = MAC_AW'(h_rd.x1);
            op_b = COEF_B1;
          end
          3'd2: begin
            op_a = MAC_AW'(h_rd.x2);
            op_b = COEF_B2;
          end
          3'd3: begin
            op_a = MAC_AW'(h_rd.y1);
            op_b = COEF_NA1;
          end
          default: begin
            op_a = MAC_AW'(h_rd.y2);
            op_b = COEF_NA2;
          end
        endcase
      end
      ST_CMAC: begin
        ctl.en  = 1'b1;
        ctl.clr = 1'b1;
        op_a    = d;
        op_b    = MAC_BW'(gain_ent);
      end
      ST_MROW: begin
        ctl.en  = 1'b1;
        ctl.clr = (step == 3'd0);
        op_b    = MAC_BW'(m_ent);
        if (jj < AXES) begin
          if (step < 3'd3) begin
            op_a = MAC_AW'(vals[jj]);
          end else begin
            op_a    = MAC_AW'(bias_ent);
            ctl.sub = 1'b1;
            ctl.shl = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Shift the history of the current axis after a filter pass
  assign h_we       = (state == ST_FEND);
  assign h_wr.x1    = v;
  assign h_wr.x2    = h_rd.x1;
  assign h_wr.y1    = y_filt;
  assign h_wr.y2    = h_rd.y1;

  imusf_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  imusf_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .sel     (kind == KIND_MAG),
    .axis    (axis),
    .wr_en   (h_we),
    .wr_data (h_wr),
    .rd_data (h_rd)
  );

  // Sequence one sample through the shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      axis     <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it this cycle
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind    <= s_tuser;
            raw_vec <= s_tdata;
            axis    <= '0;
            step    <= '0;
            for (int a = 0; a < 3; a++) begin
              vals[a] <= '0;
              calr[a] <= '0;
            end
            state <= (s_tuser == KIND_NONE) ? ST_DONE : ST_LOAD;
          end
        end
        ST_LOAD: begin
          step <= '0;
          case (kind)
            KIND_ACCEL: begin
              v <= sat32(ACC_W'(raw_cur) <<< ACC_SH);
              if (mode[0]) begin
                state <= ST_FMAC;
              end else begin
                state <= mode[2] ? ST_CSUB : ST_AXEND;
              end
            end
            KIND_MAG: begin
              v     <= sat32(ACC_W'(raw_cur) <<< FRAC_BITS);
              state <= mode[1] ? ST_FMAC : ST_AXEND;
            end
            default: state <= ST_GEND;
          endcase
        end
        ST_FMAC: begin
          step <= step + 3'd1;
          if (step == 3'd4) begin
            state <= ST_FEND;
          end
        end
        ST_FEND: begin
          v     <= y_filt;
          state <= ((kind == KIND_ACCEL) && mode[2]) ? ST_CSUB : ST_AXEND;
        end
        ST_CSUB: begin
          d     <= MAC_AW'(v) - acc_off_al;
          state <= ST_CMAC;
        end
        ST_CMAC: state <= ST_CEND;
        ST_CEND: begin
          v     <= sat32((acc + CAL_RND) >>> 14);
          state <= ST_AXEND;
        end
        ST_GEND: begin
          v     <= sat32((acc + GY_RND) >>> GY_SH);
          state <= mode[2] ? ST_GSUB : ST_AXEND;
        end
        ST_GSUB: begin
          v     <= sat32(ACC_W'(v) - ACC_W'(gyr_off_al));
          state <= ST_AXEND;
        end
        ST_AXEND: begin
          vals[axis] <= v;
          step       <= '0;
          if (axis == LAST_AXIS) begin
            axis  <= '0;
            state <= mag_cal ? ST_MROW : ST_DONE;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_LOAD;
          end
        end
        ST_MROW: begin
          step <= step + 3'd1;
          if (step == 3'd5) begin
            state <= ST_MEND;
          end
        end
        ST_MEND: begin
          calr[axis] <= sat32((acc + CAL_RND) >>> 14);
          step       <= '0;
          if (axis == LAST_AXIS) begin
            state <= ST_DONE;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_MROW;
          end
        end
        ST_DONE: begin
          // Hand over once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tuser  <= kind;
            m_tdata  <= mag_cal ? {calr[2], calr[1], calr[0]} : {vals[2], vals[1], vals[0]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/imusf_mac.sv
// Shared multiply-accumulate unit with optional left shift and subtract.
module imusf_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  imusf_pkg::mac_ctl_t                  ctl,
  input  logic signed [imusf_pkg::MAC_AW-1:0]  op_a,
  input  logic signed [imusf_pkg::MAC_BW-1:0]  op_b,
  output logic signed [imusf_pkg::ACC_W-1:0]   acc
);
  import imusf_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;

  // Form the product and align it
  assign prod = $signed(op_a) * $signed(op_b);
  assign term = ctl.shl ? (prod <<< FRAC_BITS) : prod;
  assign base = ctl.clr ? '0 : acc;

  // Accumulate
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= ctl.sub ? (base - term) : (base + term);
    end
  end

endmodule

>>> src/imusf_hist.sv
// Low-pass filter history for accelerometer and magnetometer axes.
module imusf_hist (
  input  logic               clk,
  input  logic               rst,
  input  logic               sel,
  input  logic [1:0]         axis,
  input  logic               wr_en,
  input  imusf_pkg::hist_t   wr_data,
  output imusf_pkg::hist_t   rd_data
);
  import imusf_pkg::*;

  hist_t hist [0:1][0:2];

  // Read the selected axis
  assign rd_data = hist[sel][axis];

  // Clear at reset, update one axis after each filter pass
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        for (int a = 0; a < 3; a++) begin
          hist[s][a] <= '0;
        end
      end
    end else if (wr_en) begin
      hist[sel][axis] <= wr_data;
    end
  end

endmodule

>>> src/imusf_checker.sv
// Port-level checker for the sensor conditioning block, bound to the top level.
`include "imu_sample_filter_calibrate_assert.svh"

module imusf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  // No result is offered right after reset
  `IMUSF_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !m_tvalid)

  // The block is busy in the cycle after it takes a sample
  `IMUSF_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready)

  // A stalled result holds
  `IMUSF_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind imu_sample_filter_calibrate imusf_checker u_imusf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/tb_top.sv
// Self-checking testbench for the IMU sample scaling, low-pass and calibration block.
`timescale 1ns / 1ps

module tb_top;
  import imusf_pkg::*;

  localparam int FRAC = 16;
  localparam int NAXES = 3;
  localparam int N_RANDOM = 1830;

  // Sensor kinds
  localparam logic [1:0] KIND_ACCEL  = 2'd0;
  localparam logic [1:0] KIND_GYRO   = 2'd1;
  localparam logic [1:0] KIND_MAG    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_ACC_OFS    = 3'd1;
  localparam logic [2:0] REG_ACC_SCALE  = 3'd2;
  localparam logic [2:0] REG_GYRO_OFS   = 3'd3;
  localparam logic [2:0] REG_MAG_OFS    = 3'd4;
  localparam logic [2:0] REG_MAG_ROW0   = 3'd5;
  localparam logic [2:0] REG_MAG_ROW1   = 3'd6;
  localparam logic [2:0] REG_MAG_ROW2   = 3'd7;

  // Mode bits
  localparam int MODE_ACC_FILT = 0;
  localparam int MODE_MAG_FILT = 1;
  localparam int MODE_CAL      = 2;

  // Low-pass coefficients, Q28
  localparam longint LP_B0  = 1487862;
  localparam longint LP_B1  = 2975724;
  localparam longint LP_NA1 = 477447832;
  localparam longint LP_A2  = 214963824;
  localparam longint GYRO_GAIN = 5214701;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] raw;
  } sample_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [95:0] vals;
  } cond_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  imu_sample_filter_calibrate u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of registers and filter history
  logic [2:0]  mode_q;
  logic [47:0] regs_q [1:7];
  longint      acc_xh [6];
  longint      acc_yh [6];
  longint      mag_xh [6];
  longint      mag_yh [6];

  sample_t pending_samples[$];
  cond_t   expected_conds[$];
  int      mismatch_count;
  int      samples_sent;
  bit      stim_done;
  bit      hold_off;

  // Rounded arithmetic shift, ties toward plus infinity
  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint field16(logic [47:0] r, int i);
    return longint'($signed(r[16*i +: 16]));
  endfunction

  function automatic longint q12_to_frac(longint v);
    return v * (longint'(1) <<< (FRAC - 12));
  endfunction

  // Advance one axis of the IIR and return its output
  function automatic longint iir_step(ref longint xh[6], ref longint yh[6], input int a,
                                      input longint x);
    longint acc;
    longint y;
    acc = LP_B0 * x + LP_B1 * xh[2*a] + LP_B0 * xh[2*a+1]
        + LP_NA1 * yh[2*a] - LP_A2 * yh[2*a+1];
    y = clip32(round_shift(acc, 28));
    xh[2*a+1] = xh[2*a];
    xh[2*a]   = x;
    yh[2*a+1] = yh[2*a];
    yh[2*a]   = y;
    return y;
  endfunction

  function automatic cond_t condition_sample(sample_t smp);
    cond_t  res;
    longint v[3];
    longint r[3];
    longint d[3];
    longint s;
    bit     cal;
    cal = mode_q[MODE_CAL];
    for (int a = 0; a < 3; a++) begin
      v[a] = 0;
      r[a] = 0;
    end
    case (smp.kind)
      KIND_ACCEL: begin
        for (int a = 0; a < NAXES; a++) begin
          v[a] = field16(smp.raw, a) * (longint'(1) <<< (FRAC - 8));
          if (mode_q[MODE_ACC_FILT]) v[a] = iir_step(acc_xh, acc_yh, a, v[a]);
          if (cal)
            v[a] = clip32(round_shift((v[a] - q12_to_frac(field16(regs_q[REG_ACC_OFS], a)))
                                      * field16(regs_q[REG_ACC_SCALE], a), 14));
          r[a] = v[a];
        end
      end
      KIND_GYRO: begin
        for (int a = 0; a < NAXES; a++) begin
          v[a] = clip32(round_shift(field16(smp.raw, a) * GYRO_GAIN, 32 - FRAC));
          if (cal) v[a] = clip32(v[a] - q12_to_frac(field16(regs_q[REG_GYRO_OFS], a)));
          r[a] = v[a];
        end
      end
      KIND_MAG: begin
        for (int a = 0; a < NAXES; a++) begin
          v[a] = clip32(field16(smp.raw, a) * (longint'(1) <<< FRAC));
          if (mode_q[MODE_MAG_FILT]) v[a] = iir_step(mag_xh, mag_yh, a, v[a]);
          r[a] = v[a];
        end
        if (cal) begin
          for (int j = 0; j < NAXES; j++)
            d[j] = v[j] - field16(regs_q[REG_MAG_OFS], j) * (longint'(1) <<< FRAC);
          for (int a = 0; a < NAXES; a++) begin
            s = 0;
            for (int j = 0; j < NAXES; j++)
              s += field16(regs_q[REG_MAG_ROW0 + a], j) * d[j];
            r[a] = clip32(round_shift(s, 14));
          end
        end
      end
      default: ;
    endcase
    res.kind = smp.kind;
    res.vals = {r[2][31:0], r[1][31:0], r[0][31:0]};
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample driver with random gaps
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (s_tvalid && !s_tready) begin
      // hold the beat
    end else begin
      if (s_tvalid) samples_sent <= samples_sent + 1;
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() > 0) begin
        sample_t smp;
        smp = pending_samples.pop_front();
        expected_conds.push_back(condition_sample(smp));
        s_tvalid <= 1'b1;
        s_tdata  <= smp.raw;
        s_tuser  <= smp.kind;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor with random stalls and long hold-off
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_conds.size() == 0) begin
          report_mismatch("unexpected beat", {30'd0, m_tuser}, 32'd0);
        end else begin
          cond_t want;
          want = expected_conds.pop_front();
          if (m_tuser !== want.kind)
            report_mismatch("sensor_kind", {30'd0, m_tuser}, {30'd0, want.kind});
          if (m_tdata[31:0] !== want.vals[31:0])
            report_mismatch("x_out", m_tdata[31:0], want.vals[31:0]);
          if (m_tdata[63:32] !== want.vals[63:32])
            report_mismatch("y_out", m_tdata[63:32], want.vals[63:32]);
          if (m_tdata[95:64] !== want.vals[95:64])
            report_mismatch("z_out", m_tdata[95:64], want.vals[95:64]);
        end
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready   <= 1'b1;
        if (m_tvalid && m_tready)
          stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      end
    end
  end

  // Write one register while idle
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MODE) mode_q = val[2:0];
    else regs_q[idx] = val;
  endtask

  // Wait until every expected result has come, then let the block settle
  task automatic drain_results();
    while (pending_samples.size() > 0 || s_tvalid || expected_conds.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic queue_sample(input logic [1:0] kind, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z);
    sample_t smp;
    smp.kind = kind;
    smp.raw  = {z, y, x};
    pending_samples.push_back(smp);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // Stimulus
  initial begin
    logic [15:0] ext [4];
    ext[0] = 16'h8000; ext[1] = 16'h7fff; ext[2] = 16'h0000; ext[3] = 16'hffff;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    mismatch_count = 0; samples_sent = 0; stim_done = 0; hold_off = 0;
    mode_q = '0;
    regs_q[REG_ACC_OFS] = '0;   regs_q[REG_ACC_SCALE] = 48'h400040004000;
    regs_q[REG_GYRO_OFS] = '0;  regs_q[REG_MAG_OFS] = '0;
    regs_q[REG_MAG_ROW0] = 48'h4000; regs_q[REG_MAG_ROW1] = 48'h40000000;
    regs_q[REG_MAG_ROW2] = 48'h400000000000;
    for (int i = 0; i < 6; i++) begin
      acc_xh[i] = 0; acc_yh[i] = 0; mag_xh[i] = 0; mag_yh[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes on every kind, reset registers, filters off
    for (int k = 0; k < 4; k++)
      for (int e = 0; e < 2; e++)
        queue_sample(k[1:0], ext[e], ext[1-e], ext[2+e]);
    drain_results();

    // Directed: filters and calibration on with extreme registers
    write_reg(REG_MODE, 48'h7);
    write_reg(REG_ACC_OFS, 48'h7fff_8000_0001);
    write_reg(REG_ACC_SCALE, 48'h8000_7fff_4000);
    write_reg(REG_GYRO_OFS, 48'h8000_7fff_ffff);
    write_reg(REG_MAG_OFS, 48'h7fff_8000_0000);
    write_reg(REG_MAG_ROW0, 48'h7fff_7fff_7fff);
    write_reg(REG_MAG_ROW1, 48'h8000_8000_8000);
    write_reg(REG_MAG_ROW2, 48'h0000_7fff_8000);
    for (int k = 0; k < 4; k++)
      for (int e = 0; e < 3; e++)
        queue_sample(k[1:0], ext[e], ext[(e+1)%4], ext[(e+2)%4]);
    drain_results();

    // Random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MODE, (ph == 7) ? 48'd0 : 48'($urandom_range(0, 7)));
      for (int r = 1; r < 8; r++) begin
        if (ph == 0) write_reg(r[2:0], 48'hffff_ffff_ffff);
        else if ($urandom_range(0, 1)) write_reg(r[2:0], rand48());
      end
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        logic [1:0] k;
        logic [15:0] ax [3];
        k = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
        for (int a = 0; a < 3; a++) begin
          case ($urandom_range(0, 5))
            0: ax[a] = ext[$urandom_range(0, 3)];
            1, 2: ax[a] = 16'($signed($urandom_range(0, 600)) - 300);
            default: ax[a] = 16'($urandom);
          endcase
        end
        queue_sample(k, ax[0], ax[1], ax[2]);
        if (ph == 3 && i == 40) begin
          // hold the receiver off while the sender keeps offering
          hold_off = 1'b1;
          repeat (400) @(posedge clk);
          hold_off = 1'b0;
        end
      end
      drain_results();
    end
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_conds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
